// ===== rtl/core/plinterp_pkg.sv =====
// Package for the piecewise linear interpolation table.
// Holds table sizes, fixed-point constants, command codes and the sequencer state type.
// Used by plinterp_div and profile_linear_interpolation.
`default_nettype none

package plinterp_pkg;

  // Table depth and derived widths.
  localparam int LEVELS = 32;
  localparam int LVL_AW = $clog2(LEVELS);
  localparam int CNT_W  = $clog2(LEVELS + 1);

  // Q16.16 data and Q0.16 interpolation ratio.
  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int RATIO_W   = FRAC_W + 1;
  localparam int RATIO_ONE = 1 << FRAC_W;
  localparam int PROD_W    = (DATA_W + 1) + (RATIO_W + 1);

  // Spans of at most 65 LSB (below 0.001) count as flat.
  localparam int FLAT_SPAN_LIMIT = 66;

  // Command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SCAN,
    ST_NORM,
    ST_CLASS,
    ST_DIVIDE,
    ST_MULT,
    ST_ACCUM,
    ST_DONE
  } plinterp_state_e;

endpackage

`default_nettype wire

// ===== rtl/core/profile_linear_interpolation.sv =====
// Top level of the piecewise linear interpolation table: sequencer, table RAM and datapath.
// Depends on plinterp_pkg, plinterp_ram and plinterp_div.
//
//   Channel | Direction | Handshake              | Payload
//   in      | input     | in_valid_i/in_ready_o  | command, level index/altitude/value,
//           |           |                        | level count, target, fallback
//   out     | output    | out_valid_o/out_ready_i| interpolated_value
//
// A write item leaves the sequencer idle, so the next item may follow at once. A query
// passes ST_FIRST, then as far as it needs ST_SCAN for each table level scanned (up to
// LEVELS-1) through the single RAM read port, ST_NORM, ST_CLASS, ST_DIVIDE in the bit-serial
// ratio divider, ST_MULT and ST_ACCUM, and ends in ST_DONE. in_ready_o is low while a query is in work.
// Reset clears the sequencer and the output valid; the table is undefined until written.
// A result waits in the output register while a stalled consumer holds out_ready_i low,
// and the next item may be accepted meanwhile.
`default_nettype none

module profile_linear_interpolation (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic                                   command_i,
  input  wire logic        [4:0]                      level_index_i,
  input  wire logic signed [plinterp_pkg::DATA_W-1:0] level_altitude_i,
  input  wire logic signed [plinterp_pkg::DATA_W-1:0] level_value_i,
  input  wire logic        [5:0]                      level_count_i,
  input  wire logic signed [plinterp_pkg::DATA_W-1:0] target_altitude_i,
  input  wire logic signed [plinterp_pkg::DATA_W-1:0] fallback_value_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic signed      [plinterp_pkg::DATA_W-1:0] interpolated_value_o
);
  import plinterp_pkg::*;

  plinterp_state_e state_q, state_d;

  logic                     out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] out_value_q, out_value_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [LVL_AW-1:0]        idx_q, idx_d;
  logic signed [DATA_W-1:0] target_q, target_d;
  logic signed [DATA_W-1:0] lo_alt_q, lo_alt_d;
  logic signed [DATA_W-1:0] lo_val_q, lo_val_d;
  logic signed [DATA_W-1:0] hi_val_q, hi_val_d;
  logic signed [DATA_W:0]   span_q, span_d;
  logic signed [DATA_W:0]   num_q, num_d;
  logic signed [DATA_W:0]   diff_q, diff_d;
  logic [RATIO_W-1:0]       ratio_q, ratio_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [DATA_W-1:0] result_q, result_d;

  logic                     in_accept;
  logic                     ram_we;
  logic [LVL_AW-1:0]        ram_raddr;
  logic [2*DATA_W-1:0]      ram_rdata;
  logic signed [DATA_W-1:0] rd_alt;
  logic signed [DATA_W-1:0] rd_val;
  logic                     div_start;
  logic                     div_done;
  logic [FRAC_W-1:0]        div_quot;
  logic signed [PROD_W-1:0] prod_shift;
  logic signed [DATA_W:0]   accum_sum;
  logic                     last_level;

  assign in_ready_o           = state_q == ST_IDLE;
  assign in_accept            = in_valid_i && in_ready_o;
  assign out_valid_o          = out_valid_q;
  assign interpolated_value_o = out_value_q;

  // Table write: one entry per write item, indexes past the table are dropped.
  assign ram_we = in_accept && (command_i == CMD_WRITE) && (int'(level_index_i) < LEVELS);

  plinterp_ram #(
    .WIDTH(2 * DATA_W),
    .DEPTH(LEVELS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(LVL_AW'(level_index_i)),
    .wdata_i({level_altitude_i, level_value_i}),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_alt = ram_rdata[2*DATA_W-1:DATA_W];
  assign rd_val = ram_rdata[DATA_W-1:0];

  plinterp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num_q[DATA_W-1:0]),
    .den_i  (span_q[DATA_W-1:0]),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Final scaling: floor of the product by 2^16, then offset by the lower value.
  assign prod_shift = prod_q >>> FRAC_W;
  assign accum_sum  = prod_shift[DATA_W:0] + {lo_val_q[DATA_W-1], lo_val_q};
  assign last_level = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;

  // Sequencer: next state, datapath loads, RAM address and divider start.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    count_d     = count_q;
    idx_d       = idx_q;
    target_d    = target_q;
    lo_alt_d    = lo_alt_q;
    lo_val_d    = lo_val_q;
    hi_val_d    = hi_val_q;
    span_d      = span_q;
    num_d       = num_q;
    diff_d      = diff_q;
    ratio_d     = ratio_q;
    prod_d      = prod_q;
    result_d    = result_q;
    ram_raddr   = '0;
    div_start   = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        ram_raddr = '0;
        if (in_accept && (command_i == CMD_QUERY)) begin
          target_d = target_altitude_i;
          count_d  = (int'(level_count_i) > LEVELS) ? CNT_W'(LEVELS) : CNT_W'(level_count_i);
          if (level_count_i == '0) begin
            result_d = fallback_value_i;
            state_d  = ST_DONE;
          end else begin
            state_d = ST_FIRST;
          end
        end
      end

      // Entry 0 is on the read port.
      ST_FIRST: begin
        ram_raddr = LVL_AW'(1);
        if ((count_q == CNT_W'(1)) || (target_q <= rd_alt)) begin
          result_d = rd_val;
          state_d  = ST_DONE;
        end else begin
          lo_alt_d = rd_alt;
          lo_val_d = rd_val;
          idx_d    = LVL_AW'(1);
          state_d  = ST_SCAN;
        end
      end

      // Entry idx_q is on the read port; look for the first altitude at or above target.
      ST_SCAN: begin
        ram_raddr = idx_q + LVL_AW'(1);
        if (target_q <= rd_alt) begin
          hi_val_d = rd_val;
          span_d   = {rd_alt[DATA_W-1], rd_alt} - {lo_alt_q[DATA_W-1], lo_alt_q};
          num_d    = {target_q[DATA_W-1], target_q} - {lo_alt_q[DATA_W-1], lo_alt_q};
          state_d  = ST_NORM;
        end else if (last_level) begin
          result_d = rd_val;
          state_d  = ST_DONE;
        end else begin
          lo_alt_d = rd_alt;
          lo_val_d = rd_val;
          idx_d    = idx_q + LVL_AW'(1);
        end
      end

      // Fold the sign of a falling span into the numerator.
      ST_NORM: begin
        if (span_q[DATA_W]) begin
          span_d = -span_q;
          num_d  = -num_q;
        end
        diff_d  = {hi_val_q[DATA_W-1], hi_val_q} - {lo_val_q[DATA_W-1], lo_val_q};
        state_d = ST_CLASS;
      end

      // Flat span, clamped ratio, or a real division.
      ST_CLASS: begin
        if (span_q < (DATA_W + 1)'(FLAT_SPAN_LIMIT)) begin
          result_d = hi_val_q;
          state_d  = ST_DONE;
        end else if (num_q[DATA_W] || (num_q == '0)) begin
          ratio_d = '0;
          state_d = ST_MULT;
        end else if (num_q >= span_q) begin
          ratio_d = RATIO_W'(RATIO_ONE);
          state_d = ST_MULT;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIVIDE;
        end
      end

      ST_DIVIDE: begin
        if (div_done) begin
          ratio_d = {1'b0, div_quot};
          state_d = ST_MULT;
        end
      end

      ST_MULT: begin
        prod_d  = diff_q * $signed({1'b0, ratio_q});
        state_d = ST_ACCUM;
      end

      ST_ACCUM: begin
        result_d = accum_sum[DATA_W-1:0];
        state_d  = ST_DONE;
      end

      // Hand the result to the output register once it is free.
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_value_d = result_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    count_q     <= count_d;
    idx_q       <= idx_d;
    target_q    <= target_d;
    lo_alt_q    <= lo_alt_d;
    lo_val_q    <= lo_val_d;
    hi_val_q    <= hi_val_d;
    span_q      <= span_d;
    num_q       <= num_d;
    diff_q      <= diff_d;
    ratio_q     <= ratio_d;
    prod_q      <= prod_d;
    result_q    <= result_d;
  end

  // A write item never brings up a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (command_i == CMD_WRITE) && !out_valid_o) |=> !out_valid_o)
    else $error("write item produced a result");

  // A new result only comes from the hand-off state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the hand-off state");

  // The divider finishes only while the sequencer waits on it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIVIDE))
    else $error("divider finished while not awaited");

  // The ratio fed to the multiplier never exceeds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MULT) |-> (ratio_q <= RATIO_W'(RATIO_ONE)))
    else $error("interpolation ratio above one");

endmodule

`default_nettype wire

// ===== rtl/core/plinterp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Self-contained; no package dependency.
`default_nettype none

module plinterp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/plinterp_div.sv =====
// Restoring divider that forms the Q0.16 interpolation ratio one bit per cycle.
// Depends on plinterp_pkg for data and fraction widths.
`default_nettype none

module plinterp_div (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [plinterp_pkg::DATA_W-1:0] num_i,
  input  wire logic [plinterp_pkg::DATA_W-1:0] den_i,
  output logic                                 done_o,
  output logic      [plinterp_pkg::FRAC_W-1:0] quot_o
);
  import plinterp_pkg::*;

  localparam int STEP_W = $clog2(FRAC_W);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] den_q, den_d;
  logic [FRAC_W-1:0] quot_q, quot_d;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   trial;
  logic              fits;
  logic              last_step;

  // One quotient bit per cycle: double the remainder and subtract the divisor when it fits.
  assign shifted   = {rem_q, 1'b0};
  assign fits      = shifted >= {1'b0, den_q};
  assign trial     = shifted - {1'b0, den_q};
  assign last_step = step_q == STEP_W'(FRAC_W - 1);
  assign done_o    = busy_q && last_step;
  assign quot_o    = {quot_q[FRAC_W-2:0], fits};

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = num_i;
      den_d  = den_i;
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
      quot_d = {quot_q[FRAC_W-2:0], fits};
      step_d = step_q + STEP_W'(1);
      if (last_step) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

endmodule

`default_nettype wire
